/* sv/pcv_pkg.sv */
// Shared types and constants for the per-track class vote block.
`timescale 1ns / 1ps

package pcv_pkg;

	// Command codes.
	localparam logic CMD_VOTE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Class codes.
	localparam logic [1:0] CLASS_CAR     = 2'd0;
	localparam logic [1:0] CLASS_HUMAN   = 2'd1;
	localparam logic [1:0] CLASS_BICYCLE = 2'd2;
	localparam logic [1:0] CLASS_OTHER   = 2'd3;

	// Number of counted classes per slot.
	localparam int CLASS_KINDS = 3;

	// Reset value of the min_votes register.
	localparam logic [7:0] MIN_VOTES_RESET = 8'd3;

	typedef struct packed {
		logic       cmd;
		logic [5:0] track_slot;
		logic [1:0] reported_class;
	} in_item_t;

	typedef struct packed {
		logic [5:0] slot_out;
		logic [1:0] smoothed_class;
		logic       voted;
	} out_item_t;

endpackage

/* sv/pcv_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module pcv_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/pcv_best.sv */
// Picks the leading class of a slot and decides whether it overrides the report.
`timescale 1ns / 1ps

module pcv_best #(
	parameter int COUNT_BITS = 16
) (
	input  logic [3*COUNT_BITS-1:0] counts,
	input  logic [7:0]              min_votes,
	input  logic [1:0]              reported_class,
	input  logic                    in_table,
	output logic [1:0]              smoothed_class,
	output logic                    voted
);

	localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;

	logic [COUNT_BITS-1:0] cnt_car;
	logic [COUNT_BITS-1:0] cnt_human;
	logic [COUNT_BITS-1:0] cnt_bike;
	logic [COUNT_BITS-1:0] best_cnt;
	logic [1:0]            best_class;
	logic                  reached;

	assign cnt_car   = counts[COUNT_BITS-1:0];
	assign cnt_human = counts[2*COUNT_BITS-1:COUNT_BITS];
	assign cnt_bike  = counts[3*COUNT_BITS-1:2*COUNT_BITS];

	// Strict compares keep ties on the lower class.
	always_comb begin
		best_class = pcv_pkg::CLASS_CAR;
		best_cnt   = cnt_car;
		if (cnt_human > best_cnt) begin
			best_class = pcv_pkg::CLASS_HUMAN;
			best_cnt   = cnt_human;
		end
		if (cnt_bike > best_cnt) begin
			best_class = pcv_pkg::CLASS_BICYCLE;
			best_cnt   = cnt_bike;
		end
	end

	assign reached = CMP_W'(best_cnt) >= CMP_W'(min_votes);

	always_comb begin
		if (in_table && reached) begin
			smoothed_class = best_class;
			voted          = 1'b1;
		end else begin
			smoothed_class = reported_class;
			voted          = 1'b0;
		end
	end

endmodule

/* sv/per_track_class_vote.sv */
// Top level of the per-track class vote block: vote table, update pipeline and output register.
`timescale 1ns / 1ps

// Usage: each transaction on the input channel (in_valid/in_ready, payload in_data)
// is either a clear or a vote for one track slot. A clear zeroes the slot's three
// counters and produces no output transaction. A vote bumps the counter of the
// reported class and produces exactly one output transaction (out_valid/out_ready,
// payload out_data) with the slot, the smoothed class and the voted flag.
// A vote result passes through the stage 1, stage 2 and output registers before it
// appears on out_valid. Unless out_ready held low stalls it, the block accepts one
// transaction per cycle, back to back, including repeated transactions on the same
// slot: the counter table is a single RAM with a registered read, and the read-modify-write
// of one slot per cycle is kept consistent by forwarding the last written entry.
// The user must write the min_votes register through cfg_we/cfg_wdata only while the block is
// idle; the block does not enforce this. Reset sets min_votes to 3 and empties the pipeline;
// the counter table is not cleared, so every slot must see a clear before its first vote.
// When the receiver holds out_ready low with a result pending, the whole pipeline
// freezes and in_ready drops in the same cycle; nothing is lost or repeated.
module per_track_class_vote #(
	parameter int TRACK_SLOTS = 64,
	parameter int COUNT_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pcv_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pcv_pkg::out_item_t out_data,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);

	localparam int AW    = $clog2(TRACK_SLOTS);
	localparam int ROW_W = pcv_pkg::CLASS_KINDS * COUNT_BITS;

	// Pipeline control.
	logic adv;
	logic accept;

	// Configuration.
	logic [7:0] min_votes_q;

	// Stage 1: RAM data returns, counters are updated and written back.
	logic       s1_valid_q;
	logic       s1_cmd_s1;
	logic [5:0] s1_slot_s1;
	logic [1:0] s1_class_s1;
	logic       s1_table_s1;
	logic       s1_fwd_s1;

	// Stage 2: updated counters feed the decision logic.
	logic             s2_valid_q;
	logic             s2_cmd_s2;
	logic [5:0]       s2_slot_s2;
	logic [1:0]       s2_class_s2;
	logic             s2_table_s2;
	logic [ROW_W-1:0] s2_counts_s2;

	// Output register.
	logic               out_valid_q;
	pcv_pkg::out_item_t out_q;

	// Table access.
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             in_table;
	logic             ram_we;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] last_wr_q;
	logic [ROW_W-1:0] cur_row;
	logic [ROW_W-1:0] new_row;
	logic             fwd_hit;

	logic [1:0] dec_class;
	logic       dec_voted;

	// The pipeline moves whenever the output register is empty or being drained.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	// Slot numbers are sized to the address width so that the table may be
	// smaller or larger than the six-bit slot field; the range check guards writes.
	assign rd_addr  = AW'(in_data.track_slot);
	assign wr_addr  = AW'(s1_slot_s1);
	assign in_table = 32'(in_data.track_slot) < 32'(TRACK_SLOTS);

	// The item ahead writes the same slot in the cycle this read is issued, so
	// the RAM would return the old row; take the written row instead.
	assign fwd_hit = s1_valid_q && s1_table_s1 && (in_data.track_slot == s1_slot_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_votes_q <= pcv_pkg::MIN_VOTES_RESET;
		end else if (cfg_we) begin
			min_votes_q <= cfg_wdata;
		end
	end

	pcv_ram #(
		.WIDTH(ROW_W),
		.DEPTH(TRACK_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata(new_row),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign cur_row = s1_fwd_s1 ? last_wr_q : ram_rdata;

	// A clear zeroes the row; a vote bumps the reported class, saturating.
	// The "other" class matches no counter and leaves the row unchanged.
	always_comb begin
		logic [COUNT_BITS-1:0] cnt;
		cnt     = '0;
		new_row = cur_row;
		if (s1_cmd_s1 == pcv_pkg::CMD_CLEAR) begin
			new_row = '0;
		end else begin
			for (int k = 0; k < pcv_pkg::CLASS_KINDS; k++) begin
				cnt = cur_row[k*COUNT_BITS +: COUNT_BITS];
				if (s1_class_s1 == 2'(k) && cnt != {COUNT_BITS{1'b1}}) begin
					new_row[k*COUNT_BITS +: COUNT_BITS] = cnt + COUNT_BITS'(1);
				end
			end
		end
	end

	assign ram_we = s1_valid_q && s1_table_s1 && adv;

	always_ff @(posedge clk) begin
		if (ram_we) begin
			last_wr_q <= new_row;
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_cmd_s1   <= in_data.cmd;
			s1_slot_s1  <= in_data.track_slot;
			s1_class_s1 <= in_data.reported_class;
			s1_table_s1 <= in_table;
			s1_fwd_s1   <= fwd_hit;
		end
	end

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			s2_cmd_s2    <= s1_cmd_s1;
			s2_slot_s2   <= s1_slot_s1;
			s2_class_s2  <= s1_class_s1;
			s2_table_s2  <= s1_table_s1;
			s2_counts_s2 <= new_row;
		end
	end

	pcv_best #(
		.COUNT_BITS(COUNT_BITS)
	) u_best (
		.counts        (s2_counts_s2),
		.min_votes     (min_votes_q),
		.reported_class(s2_class_s2),
		.in_table      (s2_table_s2),
		.smoothed_class(dec_class),
		.voted         (dec_voted)
	);

	// Output register: only votes produce a transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s2_valid_q && (s2_cmd_s2 == pcv_pkg::CMD_VOTE);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_valid_q) begin
			out_q.slot_out       <= s2_slot_s2;
			out_q.smoothed_class <= dec_class;
			out_q.voted          <= dec_voted;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
